@@ hdl/sfp_pkg.sv @@
package sfp_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int POS_W       = 5;

    localparam logic [7:0] SYNC_BYTE = 8'h5A;
    localparam logic [7:0] KIND_BYTE = 8'h15;

    localparam int          DIVISOR   = 100;
    localparam logic [12:0] DIV_RECIP = 13'd5243;
    localparam int          DIV_SHIFT = 19;

    localparam int LUX_W  = 26;
    localparam int TEMP_W = 10;
    localparam int PRES_W = 26;
    localparam int HUM_W  = 10;
    localparam int ALT_W  = 16;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_SYNC0      = 5'd0;
    localparam t_pos POS_SYNC1      = 5'd1;
    localparam t_pos POS_KIND       = 5'd2;
    localparam t_pos POS_LUX_FIRST  = 5'd4;
    localparam t_pos POS_LUX_LAST   = 5'd7;
    localparam t_pos POS_LUX_SUM    = 5'd8;
    localparam t_pos POS_ENV_FIRST  = 5'd9;
    localparam t_pos POS_TEMP_FIRST = 5'd13;
    localparam t_pos POS_TEMP_LAST  = 5'd14;
    localparam t_pos POS_PRES_FIRST = 5'd15;
    localparam t_pos POS_PRES_LAST  = 5'd18;
    localparam t_pos POS_HUM_FIRST  = 5'd19;
    localparam t_pos POS_HUM_LAST   = 5'd20;
    localparam t_pos POS_ALT_FIRST  = 5'd21;
    localparam t_pos POS_ALT_LAST   = 5'd22;
    localparam t_pos POS_LAST       = 5'd23;

    typedef struct packed {
        logic [7:0] q;
        logic [6:0] rem;
    } t_div;

    typedef struct packed {
        logic [LUX_W-1:0]  lux;
        logic              lux_ok;
        logic [TEMP_W-1:0] temperature;
        logic [PRES_W-1:0] pressure;
        logic [HUM_W-1:0]  humidity;
        logic [ALT_W-1:0]  altitude;
        logic              env_ok;
    } t_result;

    typedef struct packed {
        logic step;
        logic last;
    } t_track_ctl;

    function automatic t_div div100_step(input logic [6:0] rem, input logic [7:0] b);
        logic [14:0] num;
        logic [27:0] prod;
        logic [14:0] back;
        t_div        res;
        num      = {rem, b};
        prod     = 28'(num) * 28'(DIV_RECIP);
        res.q    = prod[DIV_SHIFT +: 8];
        back     = 15'(res.q) * 15'(DIVISOR);
        res.rem  = 7'(num - back);
        return res;
    endfunction

endpackage

@@ hdl/sfp_if.sv @@
interface sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LUX_W-1:0]  lux;
    logic              lux_ok;
    logic [TEMP_W-1:0] temperature;
    logic [PRES_W-1:0] pressure;
    logic [HUM_W-1:0]  humidity;
    logic [ALT_W-1:0]  altitude;
    logic              env_ok;

    modport source (output valid, output lux, output lux_ok, output temperature,
                    output pressure, output humidity, output altitude, output env_ok,
                    input ready);
    modport sink   (input valid, input lux, input lux_ok, input temperature,
                    input pressure, input humidity, input altitude, input env_ok,
                    output ready);
endinterface

@@ hdl/sfp_frame_tracker.sv @@
module sfp_frame_tracker import sfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_last,
    output t_result    o_result
);

    t_pos              r_count,  n_count;
    logic [7:0]        r_sum_a,  n_sum_a;
    logic [7:0]        r_sum_e,  n_sum_e;
    logic              r_lux_ok, n_lux_ok;
    logic [6:0]        r_rem,    n_rem;
    logic [LUX_W-1:0]  r_lux_q,  n_lux_q;
    logic [TEMP_W-1:0] r_temp_q, n_temp_q;
    logic [PRES_W-1:0] r_pres_q, n_pres_q;
    logic [HUM_W-1:0]  r_hum_q,  n_hum_q;
    logic [ALT_W-1:0]  r_alt,    n_alt;

    t_pos       pos;
    logic       div_start;
    logic [6:0] div_rem_in;
    t_div       div_out;
    logic       hdr_bad;
    logic       env_ok;

    always_comb begin
        pos = (r_count >= t_pos'(FRAME_BYTES)) ? POS_SYNC0 : r_count;

        div_start  = (pos == POS_LUX_FIRST) || (pos == POS_TEMP_FIRST) ||
                     (pos == POS_PRES_FIRST) || (pos == POS_HUM_FIRST);
        div_rem_in = div_start ? 7'd0 : r_rem;
        div_out    = div100_step(div_rem_in, i_byte);

        hdr_bad = ((pos == POS_SYNC0) && (i_byte != SYNC_BYTE)) ||
                  ((pos == POS_SYNC1) && (i_byte != SYNC_BYTE)) ||
                  ((pos == POS_KIND)  && (i_byte != KIND_BYTE));

        n_count  = r_count;
        n_sum_a  = r_sum_a;
        n_sum_e  = r_sum_e;
        n_lux_ok = r_lux_ok;
        n_rem    = r_rem;
        n_lux_q  = r_lux_q;
        n_temp_q = r_temp_q;
        n_pres_q = r_pres_q;
        n_hum_q  = r_hum_q;
        n_alt    = r_alt;

        if (i_step) begin
            if (hdr_bad || (pos == POS_LAST)) begin
                n_count = POS_SYNC0;
            end else begin
                n_count = pos + t_pos'(1);
            end

            if (pos == POS_SYNC0) begin
                n_sum_a = i_byte;
            end else if (pos <= POS_LUX_LAST) begin
                n_sum_a = r_sum_a + i_byte;
            end

            if (pos == POS_LUX_SUM) begin
                n_lux_ok = (r_sum_a == i_byte);
            end

            if (pos == POS_ENV_FIRST) begin
                n_sum_e = i_byte;
            end else if (pos inside {[POS_ENV_FIRST:POS_ALT_LAST]}) begin
                n_sum_e = r_sum_e + i_byte;
            end

            if (pos inside {[POS_LUX_FIRST:POS_LUX_LAST]}) begin
                n_rem   = div_out.rem;
                n_lux_q = {r_lux_q[LUX_W-9:0], div_out.q};
            end
            if (pos inside {[POS_TEMP_FIRST:POS_TEMP_LAST]}) begin
                n_rem    = div_out.rem;
                n_temp_q = {r_temp_q[TEMP_W-9:0], div_out.q};
            end
            if (pos inside {[POS_PRES_FIRST:POS_PRES_LAST]}) begin
                n_rem    = div_out.rem;
                n_pres_q = {r_pres_q[PRES_W-9:0], div_out.q};
            end
            if (pos inside {[POS_HUM_FIRST:POS_HUM_LAST]}) begin
                n_rem   = div_out.rem;
                n_hum_q = {r_hum_q[HUM_W-9:0], div_out.q};
            end
            if (pos inside {[POS_ALT_FIRST:POS_ALT_LAST]}) begin
                n_alt = {r_alt[ALT_W-9:0], i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_SYNC0;
        end else begin
            r_count <= n_count;
        end
        r_sum_a  <= n_sum_a;
        r_sum_e  <= n_sum_e;
        r_lux_ok <= n_lux_ok;
        r_rem    <= n_rem;
        r_lux_q  <= n_lux_q;
        r_temp_q <= n_temp_q;
        r_pres_q <= n_pres_q;
        r_hum_q  <= n_hum_q;
        r_alt    <= n_alt;
    end

    always_comb begin
        env_ok               = (r_sum_e == i_byte);
        o_last               = (pos == POS_LAST);
        o_result.lux         = r_lux_ok ? r_lux_q : '0;
        o_result.lux_ok      = r_lux_ok;
        o_result.temperature = env_ok ? r_temp_q : '0;
        o_result.pressure    = env_ok ? r_pres_q : '0;
        o_result.humidity    = env_ok ? r_hum_q : '0;
        o_result.altitude    = env_ok ? r_alt : '0;
        o_result.env_ok      = env_ok;
    end

endmodule

@@ hdl/sensor_frame_parser_core.sv @@
// Sensor frame parser. Takes one received byte per transaction and emits one
// result transaction for each complete 24-byte frame that starts with 5A 5A 15;
// a byte that breaks the header is dropped and the frame restarts. A byte is
// taken every cycle unless the input stalls: it lands in an input register, and
// the frame tracker folds it into running checksums, an altitude shift register
// and a radix-256 long division by 100 (one quotient byte per dividend byte), so
// the result is ready as the last byte leaves the input register. The result
// sits in an output register; input stalls only while a finished result is
// still waiting and the next byte would complete another frame. The lux group
// and the environment group each carry a checksum flag and read as zero when
// their sum does not match.
module sensor_frame_parser_core import sfp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sfp_byte_if.sink            i_rx,
    sfp_result_if.source        o_res
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte,  n_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out,       n_out;

    t_track_ctl ctl;
    t_result    trk_result;
    logic       trk_last;
    logic       advance;

    sfp_frame_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (ctl.step),
        .i_byte   (r_in_byte),
        .o_last   (trk_last),
        .o_result (trk_result)
    );

    always_comb begin
        ctl.last   = trk_last;
        advance    = r_in_valid && (!ctl.last || !r_out_valid || o_res.ready);
        ctl.step   = advance;
        i_rx.ready = !r_in_valid || advance;

        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (i_rx.ready) begin
            n_in_valid = i_rx.valid;
            n_in_byte  = i_rx.rx_byte;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (advance && ctl.last) begin
            n_out_valid = 1'b1;
            n_out       = trk_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.lux         = r_out.lux;
    assign o_res.lux_ok      = r_out.lux_ok;
    assign o_res.temperature = r_out.temperature;
    assign o_res.pressure    = r_out.pressure;
    assign o_res.humidity    = r_out.humidity;
    assign o_res.altitude    = r_out.altitude;
    assign o_res.env_ok      = r_out.env_ok;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a stalled byte");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid ##1 r_out_valid |-> $past(advance && ctl.last))
        else $error("result appeared without a completed frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result was overwritten");

    a_lux_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.lux_ok |-> r_out.lux == '0)
        else $error("lux not cleared on checksum failure");

endmodule

@@ tb/sv/sfp_frame_checker.sv @@
`timescale 1ns / 1ps
module sfp_frame_checker import sfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfp_byte_if   i_rx,
    sfp_result_if i_res,
    output int    o_mismatches,
    output int    o_pending
);

    t_pos       frame_pos;
    logic [7:0] frame_bytes [FRAME_BYTES];
    t_result    expected_results [$];
    int         mismatch_total = 0;

    function automatic logic [7:0] byte_sum(input int first, input int last);
        logic [7:0] acc;
        acc = '0;
        for (int i = first; i <= last; i++) begin
            acc = acc + frame_bytes[i];
        end
        return acc;
    endfunction

    function automatic t_result decode_frame();
        t_result    res;
        logic [31:0] lux_raw;
        logic [31:0] pres_raw;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        lux_good;
        logic        env_good;
        lux_raw  = {frame_bytes[POS_LUX_FIRST], frame_bytes[POS_LUX_FIRST + 1],
                    frame_bytes[POS_LUX_FIRST + 2], frame_bytes[POS_LUX_LAST]};
        pres_raw = {frame_bytes[POS_PRES_FIRST], frame_bytes[POS_PRES_FIRST + 1],
                    frame_bytes[POS_PRES_FIRST + 2], frame_bytes[POS_PRES_LAST]};
        temp_raw = {frame_bytes[POS_TEMP_FIRST], frame_bytes[POS_TEMP_LAST]};
        hum_raw  = {frame_bytes[POS_HUM_FIRST], frame_bytes[POS_HUM_LAST]};
        lux_good = byte_sum(POS_SYNC0, POS_LUX_LAST) == frame_bytes[POS_LUX_SUM];
        env_good = byte_sum(POS_ENV_FIRST, POS_ALT_LAST) == frame_bytes[POS_LAST];
        res.lux_ok      = lux_good;
        res.env_ok      = env_good;
        res.lux         = lux_good ? LUX_W'(lux_raw / 32'(DIVISOR)) : '0;
        res.temperature = env_good ? TEMP_W'(temp_raw / 16'(DIVISOR)) : '0;
        res.pressure    = env_good ? PRES_W'(pres_raw / 32'(DIVISOR)) : '0;
        res.humidity    = env_good ? HUM_W'(hum_raw / 16'(DIVISOR)) : '0;
        res.altitude    = env_good ? {frame_bytes[POS_ALT_FIRST], frame_bytes[POS_ALT_LAST]}
                                   : '0;
        return res;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        t_pos pos;
        pos = frame_pos;
        frame_bytes[pos] = b;
        if ((pos == POS_SYNC0 && b != SYNC_BYTE) || (pos == POS_SYNC1 && b != SYNC_BYTE) ||
            (pos == POS_KIND && b != KIND_BYTE)) begin
            frame_pos = POS_SYNC0;
        end else if (pos != POS_LAST) begin
            frame_pos = pos + 1'b1;
        end else begin
            frame_pos = POS_SYNC0;
            expected_results.push_back(decode_frame());
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_total++;
        end else begin
            want = expected_results.pop_front();
            check_field("lux", 32'(want.lux), 32'(got.lux));
            check_field("lux_ok", 32'(want.lux_ok), 32'(got.lux_ok));
            check_field("temperature", 32'(want.temperature), 32'(got.temperature));
            check_field("pressure", 32'(want.pressure), 32'(got.pressure));
            check_field("humidity", 32'(want.humidity), 32'(got.humidity));
            check_field("altitude", 32'(want.altitude), 32'(got.altitude));
            check_field("env_ok", 32'(want.env_ok), 32'(got.env_ok));
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        if (!i_rst_n) begin
            frame_pos = POS_SYNC0;
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.lux         = i_res.lux;
                seen.lux_ok      = i_res.lux_ok;
                seen.temperature = i_res.temperature;
                seen.pressure    = i_res.pressure;
                seen.humidity    = i_res.humidity;
                seen.altitude    = i_res.altitude;
                seen.env_ok      = i_res.env_ok;
                check_result(seen);
            end
            if (i_rx.valid && i_rx.ready) begin
                absorb_byte(i_rx.rx_byte);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/sv/tb_sensor_frame_parser_core.sv @@
`timescale 1ns / 1ps
module tb_sensor_frame_parser_core import sfp_pkg::*;;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int BYTE_TARGET   = 950;
    localparam int FRAME_TARGET  = 40;
    localparam int PAYLOAD_MIX   = 0;
    localparam int PAYLOAD_ONES  = 1;
    localparam int PAYLOAD_ZEROS = 2;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   frames_sent = 0;
    int   mismatch_count;
    int   results_pending;
    bit   quiet = 0;
    bit   paused_midway = 0;

    sfp_byte_if   rx_if ();
    sfp_result_if res_if ();

    sensor_frame_parser_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    sfp_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .o_mismatches (mismatch_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] payload_byte(input int mode);
        int pick;
        pick = $urandom_range(0, 3);
        if (mode == PAYLOAD_ONES) return 8'hFF;
        if (mode == PAYLOAD_ZEROS) return 8'h00;
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit lux_bad, input bit env_bad, input int mode);
        logic [7:0] fr [FRAME_BYTES];
        logic [7:0] sum;
        fr[POS_SYNC0] = SYNC_BYTE;
        fr[POS_SYNC1] = SYNC_BYTE;
        fr[POS_KIND]  = KIND_BYTE;
        for (int i = POS_KIND + 1; i < FRAME_BYTES; i++) begin
            fr[i] = payload_byte(mode);
        end
        sum = '0;
        for (int i = POS_SYNC0; i <= POS_LUX_LAST; i++) sum = sum + fr[i];
        fr[POS_LUX_SUM] = lux_bad ? sum + 8'($urandom_range(1, 255)) : sum;
        sum = '0;
        for (int i = POS_ENV_FIRST; i <= POS_ALT_LAST; i++) sum = sum + fr[i];
        fr[POS_LAST] = env_bad ? sum + 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i]);
        frames_sent++;
    endtask

    task automatic send_broken_header();
        logic [7:0] b;
        b = 8'($urandom);
        send_byte(SYNC_BYTE);
        if ($urandom_range(0, 1) == 1) begin
            send_byte(SYNC_BYTE);
            if (b == KIND_BYTE) b = ~b;
        end else if (b == SYNC_BYTE) begin
            b = ~b;
        end
        send_byte(b);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    initial begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            repeat (stall) begin
                res_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        int mode;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // broken headers: bad first byte, bad second byte, third byte repeats sync
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'h11);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(KIND_BYTE);
        send_frame(1'b0, 1'b0, PAYLOAD_ONES);
        wait_drained();

        while (bytes_sent < BYTE_TARGET || frames_sent < FRAME_TARGET) begin
            quiet = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 11))
                0: begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                end
                1: begin
                    send_broken_header();
                end
                default: begin
                    mode = $urandom_range(0, 19);
                    if (mode > PAYLOAD_ZEROS) mode = PAYLOAD_MIX;
                    send_frame($urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0, mode);
                end
            endcase
            if (!paused_midway && bytes_sent >= BYTE_TARGET / 2) begin
                wait_drained();
                paused_midway = 1;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
